>>> rtl/gn3_pkg.sv
// shared types, constants and gradient function for the octave gradient noise block
package gn3_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = 8;
  localparam int PERM_DW   = 8;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 1'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int FADE_W  = 17;
  localparam int AMP_W   = 17;
  localparam int PERS_W  = 16;
  localparam int OCTC_W  = 4;
  localparam int GRAD_W  = 20;
  localparam int CRN_W   = 18;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 48;
  localparam int Q_SH    = 16;
  localparam int OUT_W   = 16;
  localparam int OUT_SH  = 15;

  localparam int ONE_Q16 = 65536;
  localparam int FADE_A  = 6;
  localparam int FADE_B  = 15;
  localparam int FADE_C  = 10;

  localparam logic [OCTC_W-1:0] OCT_RESET  = 4'd1;
  localparam logic [PERS_W-1:0] PERS_RESET = 16'd32768;

  localparam logic [3:0] GRAD_U_LIM = 4'd8;
  localparam logic [3:0] GRAD_V_LIM = 4'd4;
  localparam logic [3:0] GRAD_V_X0  = 4'd12;
  localparam logic [3:0] GRAD_V_X1  = 4'd14;

  function automatic logic signed [GRAD_W-1:0] grad(
    input logic [3:0]              h,
    input logic signed [CRN_W-1:0] x,
    input logic signed [CRN_W-1:0] y,
    input logic signed [CRN_W-1:0] z
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = (h < GRAD_U_LIM) ? GRAD_W'(x) : GRAD_W'(y);
    if (h < GRAD_V_LIM) begin
      v = GRAD_W'(y);
    end else if (h == GRAD_V_X0 || h == GRAD_V_X1) begin
      v = GRAD_W'(x);
    end else begin
      v = GRAD_W'(z);
    end
    if (h[0]) begin
      u = -u;
    end
    if (h[1]) begin
      v = -v;
    end
    return u + v;
  endfunction

endpackage

>>> rtl/gradient_noise_3d_octaves.sv
// top level: sequencer for octave gradient noise over a shared multiplier and table port
// A load item writes one permutation entry and leaves the input open. An evaluate item
// runs the octaves one by one, each paced by the single shared multiplier and the single
// read port of the permutation table (14 table reads overlap the three fades, then a
// chain of seven lerps, the scaling and accumulation, and the amplitude update), followed
// by a bit-serial divide and the result transfer. The input is stalled from the accepted
// evaluate item until its result is taken.
// The permutation table has no reset; every entry an evaluation reaches must be loaded.
module gradient_noise_3d_octaves #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [gn3_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gn3_pkg::CFG_DW-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [7:0]                            in_perm_index,
  input  logic [7:0]                            in_perm_value,
  input  logic signed [gn3_pkg::COORD_W-1:0]    in_x_coord,
  input  logic signed [gn3_pkg::COORD_W-1:0]    in_y_coord,
  input  logic signed [gn3_pkg::COORD_W-1:0]    in_z_coord,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gn3_pkg::OUT_W-1:0]      out_noise_value
);

  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int TW     = 20 + OCT_W;
  localparam int MW     = 17 + OCT_W;
  localparam int NW     = TW + gn3_pkg::OUT_SH;
  localparam int SW     = gn3_pkg::COORD_W + MAX_OCTAVES;
  localparam int PSH_W  = gn3_pkg::PROD_W - gn3_pkg::Q_SH;
  localparam int GW     = gn3_pkg::GRAD_W;
  localparam int MUL_W  = gn3_pkg::MUL_W;
  localparam int FW     = gn3_pkg::FADE_W;
  localparam int AW     = gn3_pkg::PERM_AW;

  localparam logic [4:0] S_RD_X     = 5'd0;
  localparam logic [4:0] S_RD_X1    = 5'd1;
  localparam logic [4:0] S_RD_A     = 5'd2;
  localparam logic [4:0] S_RD_A1    = 5'd3;
  localparam logic [4:0] S_RD_B     = 5'd4;
  localparam logic [4:0] S_RD_B1    = 5'd5;
  localparam logic [4:0] S_RD_AA    = 5'd6;
  localparam logic [4:0] S_RD_BA    = 5'd7;
  localparam logic [4:0] S_RD_AB    = 5'd8;
  localparam logic [4:0] S_RD_BB    = 5'd9;
  localparam logic [4:0] S_RD_AA1   = 5'd10;
  localparam logic [4:0] S_RD_BA1   = 5'd11;
  localparam logic [4:0] S_RD_AB1   = 5'd12;
  localparam logic [4:0] S_RD_BB1   = 5'd13;
  localparam logic [4:0] S_GRD_LAST = 5'd14;
  localparam logic [4:0] S_FADE_END = 5'd12;
  localparam logic [4:0] S_L0       = 5'd15;
  localparam logic [4:0] S_L1       = 5'd16;
  localparam logic [4:0] S_L3       = 5'd17;
  localparam logic [4:0] S_L4       = 5'd18;
  localparam logic [4:0] S_L2       = 5'd19;
  localparam logic [4:0] S_L5       = 5'd20;
  localparam logic [4:0] S_L6       = 5'd21;
  localparam logic [4:0] S_NOISE    = 5'd22;
  localparam logic [4:0] S_ACC      = 5'd23;
  localparam logic [4:0] S_AMP      = 5'd24;

  localparam logic [1:0] F_SQ  = 2'd0;
  localparam logic [1:0] F_CUB = 2'd1;
  localparam logic [1:0] F_POL = 2'd2;
  localparam logic [1:0] F_CAP = 2'd3;

  gn3_pkg::state_t state_r, state_nxt;
  logic [4:0]      step_r, step_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic [OCT_W-1:0] noct_r, noct_nxt;
  logic [gn3_pkg::OCTC_W-1:0] octc_r, octc_nxt;
  logic [gn3_pkg::PERS_W-1:0] pers_r, pers_nxt;

  logic signed [gn3_pkg::COORD_W-1:0] coord_r [3];
  logic signed [gn3_pkg::COORD_W-1:0] coord_nxt [3];
  logic [gn3_pkg::AMP_W-1:0] amp_r, amp_nxt;
  logic signed [TW-1:0]      total_r, total_nxt;
  logic [MW-1:0]             maxv_r, maxv_nxt;
  logic [FW-1:0]             t2_r, t2_nxt;
  logic [FW-1:0]             fade_r [3];
  logic [FW-1:0]             fade_nxt [3];
  logic [AW-1:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic [AW-1:0] haa_r, haa_nxt, hab_r, hab_nxt, hba_r, hba_nxt, hbb_r, hbb_nxt;
  logic signed [GW-1:0] g_r [8];
  logic signed [GW-1:0] g_nxt [8];
  logic signed [GW-1:0] lv_r [5];
  logic signed [GW-1:0] lv_nxt [5];
  logic signed [GW-1:0] la_r, la_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [gn3_pkg::OUT_W-1:0] noise_r, noise_nxt;

  logic [SW-1:0]               sh [3];
  logic [AW-1:0]               cell_idx [3];
  logic [gn3_pkg::FRAC_W-1:0]  frac [3];

  logic signed [MUL_W-1:0]              mul_a, mul_b;
  logic signed [gn3_pkg::PROD_W-1:0]    mul_p;
  logic signed [PSH_W-1:0]              p_sh;
  logic [AW-1:0]                        ram_raddr;
  logic [gn3_pkg::PERM_DW-1:0]          ram_q;
  logic                                 ram_we;
  logic                                 in_acc;

  gn3_pkg::div_ctl_t div_ctl;
  gn3_pkg::div_sts_t div_sts;
  logic [NW-1:0]     div_num;
  logic [NW-1:0]     div_quo;
  logic [TW-1:0]     total_mag;

  logic [1:0]              ax;
  logic [FW-1:0]           tsel;
  logic signed [MUL_W-1:0] gpoly;
  logic signed [GW-1:0]    lerp_res;
  logic signed [GW-1:0]    la, lb;
  logic [FW-1:0]           lt;
  logic signed [GW:0]      ldiff;
  logic [2:0]              corner;
  logic signed [gn3_pkg::CRN_W-1:0] cx, cy, cz;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != gn3_pkg::ST_IDLE);
  assign ram_we    = in_acc && (in_action == gn3_pkg::ACT_LOAD);
  assign out_valid = (state_r == gn3_pkg::ST_OUT);
  assign out_noise_value = noise_r;
  assign p_sh      = $signed(mul_p[gn3_pkg::PROD_W-1:gn3_pkg::Q_SH]);
  assign lerp_res  = la_r + GW'(p_sh);
  assign total_mag = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
  assign div_num   = {total_mag, {gn3_pkg::OUT_SH{1'b0}}};

  gn3_ram #(
    .WIDTH (gn3_pkg::PERM_DW),
    .DEPTH (gn3_pkg::PERM_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_perm_index),
    .wdata (in_perm_value),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  gn3_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  gn3_div #(
    .NW (NW),
    .DW (MW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (maxv_r),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // lattice cell and fraction per axis for the current octave
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]       = SW'(coord_r[i]) << oct_r;
      cell_idx[i] = sh[i][FRAC_BITS+7:FRAC_BITS];
      frac[i]     = gn3_pkg::FRAC_W'({sh[i][FRAC_BITS-1:0], 16'b0} >> FRAC_BITS);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    oct_nxt   = oct_r;
    noct_nxt  = noct_r;
    octc_nxt  = octc_r;
    pers_nxt  = pers_r;
    coord_nxt = coord_r;
    amp_nxt   = amp_r;
    total_nxt = total_r;
    maxv_nxt  = maxv_r;
    t2_nxt    = t2_r;
    fade_nxt  = fade_r;
    ha_nxt    = ha_r;
    hb_nxt    = hb_r;
    haa_nxt   = haa_r;
    hab_nxt   = hab_r;
    hba_nxt   = hba_r;
    hbb_nxt   = hbb_r;
    g_nxt     = g_r;
    lv_nxt    = lv_r;
    la_nxt    = la_r;
    neg_nxt   = neg_r;
    noise_nxt = noise_r;
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = cell_idx[0];
    div_ctl.start = 1'b0;
    ax        = step_r[3:2];
    tsel      = {1'b0, frac[ax]};
    gpoly     = MUL_W'(gn3_pkg::FADE_A) * $signed({7'b0, t2_r})
              - MUL_W'(gn3_pkg::FADE_B) * $signed({7'b0, tsel})
              + MUL_W'(gn3_pkg::FADE_C * gn3_pkg::ONE_Q16);
    la        = g_r[0];
    lb        = g_r[1];
    lt        = fade_r[0];
    ldiff     = '0;
    corner    = 3'(step_r - S_RD_BA);
    cx        = corner[0] ? gn3_pkg::CRN_W'($signed({2'b0, frac[0]}) - gn3_pkg::ONE_Q16)
                          : $signed({2'b0, frac[0]});
    cy        = corner[1] ? gn3_pkg::CRN_W'($signed({2'b0, frac[1]}) - gn3_pkg::ONE_Q16)
                          : $signed({2'b0, frac[1]});
    cz        = corner[2] ? gn3_pkg::CRN_W'($signed({2'b0, frac[2]}) - gn3_pkg::ONE_Q16)
                          : $signed({2'b0, frac[2]});

    if (cfg_we) begin
      unique case (cfg_index)
        gn3_pkg::CFG_OCTAVES: octc_nxt = cfg_wdata[gn3_pkg::OCTC_W-1:0];
        gn3_pkg::CFG_PERSIST: pers_nxt = cfg_wdata[gn3_pkg::PERS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      gn3_pkg::ST_IDLE: begin
        if (in_acc && in_action == gn3_pkg::ACT_EVAL) begin
          coord_nxt[0] = in_x_coord;
          coord_nxt[1] = in_y_coord;
          coord_nxt[2] = in_z_coord;
          if (octc_r == '0) begin
            noct_nxt = OCT_W'(1);
          end else if ({1'b0, octc_r} > 5'(MAX_OCTAVES)) begin
            noct_nxt = OCT_W'(MAX_OCTAVES);
          end else begin
            noct_nxt = OCT_W'(octc_r);
          end
          oct_nxt   = '0;
          step_nxt  = S_RD_X;
          amp_nxt   = gn3_pkg::AMP_W'(gn3_pkg::ONE_Q16);
          total_nxt = '0;
          maxv_nxt  = '0;
          state_nxt = gn3_pkg::ST_RUN;
        end
      end

      gn3_pkg::ST_RUN: begin
        step_nxt = step_r + 5'd1;

        // permutation table reads
        unique case (step_r)
          S_RD_X:   ram_raddr = cell_idx[0];
          S_RD_X1:  ram_raddr = cell_idx[0] + AW'(1);
          S_RD_A:   ram_raddr = ha_r;
          S_RD_A1:  ram_raddr = ha_r + AW'(1);
          S_RD_B:   ram_raddr = hb_r;
          S_RD_B1:  ram_raddr = hb_r + AW'(1);
          S_RD_AA:  ram_raddr = haa_r;
          S_RD_BA:  ram_raddr = hba_r;
          S_RD_AB:  ram_raddr = hab_r;
          S_RD_BB:  ram_raddr = hbb_r;
          S_RD_AA1: ram_raddr = haa_r + AW'(1);
          S_RD_BA1: ram_raddr = hba_r + AW'(1);
          S_RD_AB1: ram_raddr = hab_r + AW'(1);
          S_RD_BB1: ram_raddr = hbb_r + AW'(1);
          default:  ram_raddr = cell_idx[0];
        endcase

        // read data arrives in the step after its address
        unique case (step_r)
          S_RD_X1:  ha_nxt  = ram_q + cell_idx[1];
          S_RD_A:   hb_nxt  = ram_q + cell_idx[1];
          S_RD_A1:  haa_nxt = ram_q + cell_idx[2];
          S_RD_B:   hab_nxt = ram_q + cell_idx[2];
          S_RD_B1:  hba_nxt = ram_q + cell_idx[2];
          S_RD_AA:  hbb_nxt = ram_q + cell_idx[2];
          default: ;
        endcase
        if (step_r >= S_RD_BA && step_r <= S_GRD_LAST) begin
          g_nxt[corner] = gn3_pkg::grad(ram_q[3:0], cx, cy, cz);
        end

        // quintic fade, four steps per axis
        if (step_r < S_FADE_END) begin
          unique case (step_r[1:0])
            F_SQ: begin
              mul_a = $signed({7'b0, tsel});
              mul_b = $signed({7'b0, tsel});
            end
            F_CUB: begin
              t2_nxt = p_sh[FW-1:0];
              mul_a  = $signed({7'b0, p_sh[FW-1:0]});
              mul_b  = $signed({7'b0, tsel});
            end
            F_POL: begin
              mul_a = $signed({7'b0, p_sh[FW-1:0]});
              mul_b = gpoly;
            end
            F_CAP: begin
              if (p_sh[PSH_W-1]) begin
                fade_nxt[ax] = '0;
              end else if (p_sh > PSH_W'(gn3_pkg::ONE_Q16)) begin
                fade_nxt[ax] = FW'(gn3_pkg::ONE_Q16);
              end else begin
                fade_nxt[ax] = p_sh[FW-1:0];
              end
            end
            default: ;
          endcase
        end

        // trilinear lerp chain
        unique case (step_r)
          S_L0: begin lt = fade_r[0]; la = g_r[0];  lb = g_r[1];  end
          S_L1: begin lt = fade_r[0]; la = g_r[2];  lb = g_r[3];  end
          S_L3: begin lt = fade_r[0]; la = g_r[4];  lb = g_r[5];  end
          S_L4: begin lt = fade_r[0]; la = g_r[6];  lb = g_r[7];  end
          S_L2: begin lt = fade_r[1]; la = lv_r[0]; lb = lv_r[1]; end
          S_L5: begin lt = fade_r[1]; la = lv_r[2]; lb = lv_r[3]; end
          S_L6: begin lt = fade_r[2]; la = lv_r[4]; lb = lerp_res; end
          default: ;
        endcase
        if (step_r >= S_L0 && step_r <= S_L6) begin
          ldiff  = $signed({lb[GW-1], lb}) - $signed({la[GW-1], la});
          mul_a  = MUL_W'(ldiff);
          mul_b  = $signed({7'b0, lt});
          la_nxt = la;
        end
        if (step_r >= S_L1 && step_r <= S_L5) begin
          lv_nxt[3'(step_r - S_L1)] = lerp_res;
        end

        unique case (step_r)
          S_NOISE: begin
            mul_a = MUL_W'(lerp_res);
            mul_b = $signed({7'b0, amp_r});
          end
          S_ACC: begin
            total_nxt = total_r + TW'(p_sh);
            maxv_nxt  = maxv_r + MW'(amp_r);
            mul_a     = $signed({7'b0, amp_r});
            mul_b     = $signed({8'b0, pers_r});
          end
          S_AMP: begin
            amp_nxt  = p_sh[gn3_pkg::AMP_W-1:0];
            step_nxt = S_RD_X;
            if (oct_r == noct_r - OCT_W'(1)) begin
              state_nxt = gn3_pkg::ST_DIV_START;
            end else begin
              oct_nxt = oct_r + OCT_W'(1);
            end
          end
          default: ;
        endcase
      end

      gn3_pkg::ST_DIV_START: begin
        div_ctl.start = 1'b1;
        neg_nxt       = total_r[TW-1];
        state_nxt     = gn3_pkg::ST_DIV_WAIT;
      end

      gn3_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) begin
          if (neg_r) begin
            noise_nxt = (div_quo > NW'(32768)) ? 16'sh8000 : -$signed(div_quo[15:0]);
          end else begin
            noise_nxt = (div_quo > NW'(32767)) ? 16'sh7fff : $signed(div_quo[15:0]);
          end
          state_nxt = gn3_pkg::ST_OUT;
        end
      end

      gn3_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = gn3_pkg::ST_IDLE;
        end
      end

      default: state_nxt = gn3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gn3_pkg::ST_IDLE;
      step_r  <= '0;
      oct_r   <= '0;
      noct_r  <= OCT_W'(1);
      octc_r  <= gn3_pkg::OCT_RESET;
      pers_r  <= gn3_pkg::PERS_RESET;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      oct_r   <= oct_nxt;
      noct_r  <= noct_nxt;
      octc_r  <= octc_nxt;
      pers_r  <= pers_nxt;
    end
    coord_r <= coord_nxt;
    amp_r   <= amp_nxt;
    total_r <= total_nxt;
    maxv_r  <= maxv_nxt;
    t2_r    <= t2_nxt;
    fade_r  <= fade_nxt;
    ha_r    <= ha_nxt;
    hb_r    <= hb_nxt;
    haa_r   <= haa_nxt;
    hab_r   <= hab_nxt;
    hba_r   <= hba_nxt;
    hbb_r   <= hbb_nxt;
    g_r     <= g_nxt;
    lv_r    <= lv_nxt;
    la_r    <= la_nxt;
    neg_r   <= neg_nxt;
    noise_r <= noise_nxt;
  end

endmodule

>>> rtl/gn3_ram.sv
// generic single write, single read ram with registered read data
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/gn3_mul.sv
// shared signed multiplier with registered product
module gn3_mul (
  input  logic                              clk,
  input  logic signed [gn3_pkg::MUL_W-1:0]  a,
  input  logic signed [gn3_pkg::MUL_W-1:0]  b,
  output logic signed [gn3_pkg::PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> rtl/gn3_div.sv
// restoring unsigned divider, one quotient bit per cycle
module gn3_div #(
  parameter int NW = 39,
  parameter int DW = 21
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gn3_pkg::div_ctl_t         ctl,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  output gn3_pkg::div_sts_t         sts,
  output logic [NW-1:0]             quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, n_r[NW-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      n_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      n_nxt   = {n_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign sts.done = done_r;
  assign quo      = n_r;

endmodule

>>> rtl/gn3_chk.sv
// port-level checker for the octave gradient noise block, bound to the top level
module gn3_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_action,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [gn3_pkg::OUT_W-1:0] out_noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("result changed while stalled");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == gn3_pkg::ACT_EVAL |=> in_stall)
    else $error("evaluate transfer did not start work");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == gn3_pkg::ACT_LOAD |=> !out_valid && !in_stall)
    else $error("load transfer produced a result or stalled");

endmodule

bind gradient_noise_3d_octaves gn3_chk u_gn3_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);
